@@ hdl/pair_key_linear_probe_hash_set_unit_assert.svh @@
// Assertion macros for the hash set unit
`ifndef PAIR_KEY_LINEAR_PROBE_HASH_SET_UNIT_ASSERT_SVH
`define PAIR_KEY_LINEAR_PROBE_HASH_SET_UNIT_ASSERT_SVH

// Implication checked on every clock edge outside reset
`define PK_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define PK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/pkhs_pkg.sv @@
// Shared types and constants for the hash set unit
package pkhs_pkg;

    localparam int TableSize = 1021;
    localparam int SlotW     = $clog2(TableSize);
    localparam int CountW    = $clog2(TableSize + 1);
    localparam int KeyW      = 56;
    localparam int QDepth    = 2;

    // Configuration register byte addresses
    localparam logic [1:0] RegMaxFill = 2'd0;

    typedef enum logic [1:0] {
        K_LOOKUP = 2'd0,
        K_INSERT = 2'd1,
        K_CLEAR  = 2'd2,
        K_SPARE  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_ABSENT  = 3'd0,
        ST_PRESENT = 3'd1,
        ST_ADDED   = 3'd2,
        ST_REFUSED = 3'd3,
        ST_CLEARED = 3'd4
    } t_status;

    // Front stage state: sum, product halves, product, modulo reduction
    typedef enum logic [2:0] {
        F_IDLE, F_MULLO, F_MULHI, F_ADD, F_MOD, F_PUSH
    } t_fstate;

    typedef enum logic [2:0] {
        B_IDLE, B_CLEAR, B_READ, B_CHECK, B_OUT
    } t_bstate;

    // Classified operation passed from front to back
    typedef struct packed {
        logic             clr;
        logic             ins;
        logic [KeyW-1:0]  key;
        logic [SlotW-1:0] home;
    } t_op;

endpackage

@@ hdl/pair_key_linear_probe_hash_set_unit.sv @@
// Top level of the pair-key linear-probe hash set
// Channel | Direction | Handshake        | Payload
// input   | in        | i_push / o_full  | i_kind, i_tier_value, i_position_value
// result  | out       | o_empty / i_pop  | o_status, o_occupancy
// config  | in        | APB psel/penable | max_fill at byte address 0
// Front: per key a sum, a split multiply, an add and a three-step modulo fold; a clear skips to the push.
// Back: each probed slot takes a registered memory read, then a compare.
// After reset a sweep over all 1021 slots clears the slot marks before the first probe;
// the same sweep follows every 255th clear, when the epoch mark wraps.
// A two-entry queue decouples front and back; a full result register stalls the back.
module pair_key_linear_probe_hash_set_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_tier_value,
    input  logic [39:0] i_position_value,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [2:0]  o_status,
    output logic [9:0]  o_occupancy,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    `include "pair_key_linear_probe_hash_set_unit_assert.svh"

    logic          w_op_valid, w_op_take, w_idle;
    pkhs_pkg::t_op w_op;
    logic [9:0]    r_max_fill;

    assign pready = 1'b1;
    assign prdata = (paddr == pkhs_pkg::RegMaxFill) ? {22'd0, r_max_fill} : 32'd0;

    // config register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_max_fill <= 10'd765;
        else if (psel && penable && pwrite && pready && paddr == pkhs_pkg::RegMaxFill)
            r_max_fill <= pwdata[9:0];
    end

    pkhs_front u_front (
        .i_clk, .i_rst_n, .i_push, .o_full, .i_kind, .i_tier_value,
        .i_position_value, .o_op_valid(w_op_valid), .o_op(w_op),
        .i_op_take(w_op_take)
    );

    pkhs_back u_back (
        .i_clk, .i_rst_n, .i_op_valid(w_op_valid), .i_op(w_op),
        .o_op_take(w_op_take), .i_max_fill(r_max_fill), .o_empty, .i_pop,
        .o_status, .o_occupancy, .o_idle(w_idle)
    );

    `PK_ASSERT_IMPL(a_stat_range, i_clk, i_rst_n, !o_empty,
        o_status <= pkhs_pkg::ST_CLEARED, "status code out of range")
    `PK_ASSERT_NEXT(a_clear_zero, i_clk, i_rst_n,
        !o_empty && o_status == pkhs_pkg::ST_CLEARED && !i_pop, o_occupancy == 10'd0,
        "occupancy not zero after clear")
    `PK_ASSERT_NEXT(a_occ_hold, i_clk, i_rst_n, w_idle && !o_empty,
        $stable(o_occupancy) || o_status == pkhs_pkg::ST_CLEARED,
        "occupancy moved while idle")
endmodule

@@ hdl/pkhs_front.sv @@
// Front end: home slot computation and the hand-off queue
module pkhs_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic [1:0]           i_kind,
    input  logic [15:0]          i_tier_value,
    input  logic [39:0]          i_position_value,
    output logic                 o_op_valid,
    output pkhs_pkg::t_op        o_op,
    input  logic                 i_op_take
);
    pkhs_pkg::t_fstate r_st, n_st;
    logic [15:0]  r_a;
    logic [39:0]  r_b;
    logic         r_clr, r_ins;
    logic [40:0]  r_x;     // s or s/2
    logic [41:0]  r_y;     // (s+1)/2 or s+1
    logic [63:0]  r_lo, r_hi, r_p;
    logic [1:0]   r_mcnt;  // modulo fold step
    logic [18:0]  r_rem;
    logic [18:0]  n_rem;
    logic [10:0]  w_low;

    // queue
    pkhs_pkg::t_op r_q [pkhs_pkg::QDepth];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic w_enq, w_deq;

    assign o_full = (r_st != pkhs_pkg::F_IDLE);

    // remainder by folding: 1024 is 3 modulo 1021, three steps
    always_comb begin
        w_low = '0;
        n_rem = r_rem;
        case (r_mcnt)
            2'd0: n_rem = 19'(r_p[9:0]) + 19'(r_p[19:10]) * 19'd3
                + 19'(r_p[29:20]) * 19'd9 + 19'(r_p[39:30]) * 19'd27
                + 19'(r_p[49:40]) * 19'd81 + 19'(r_p[59:50]) * 19'd243
                + 19'(r_p[63:60]) * 19'd729;
            2'd1: n_rem = 19'(r_rem[18:10]) * 19'd3 + 19'(r_rem[9:0]);
            default: begin
                w_low = 11'(r_rem[11:10]) * 11'd3 + 11'(r_rem[9:0]);
                n_rem = (w_low >= 11'(pkhs_pkg::TableSize))
                    ? 19'(w_low - 11'(pkhs_pkg::TableSize)) : 19'(w_low);
            end
        endcase
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            pkhs_pkg::F_IDLE:  if (i_push) n_st = pkhs_pkg::F_MULLO;
            pkhs_pkg::F_MULLO: n_st = r_clr ? pkhs_pkg::F_PUSH : pkhs_pkg::F_MULHI;
            pkhs_pkg::F_MULHI: n_st = pkhs_pkg::F_ADD;
            pkhs_pkg::F_ADD:   n_st = pkhs_pkg::F_MOD;
            pkhs_pkg::F_MOD:   if (r_mcnt == 2'd2) n_st = pkhs_pkg::F_PUSH;
            pkhs_pkg::F_PUSH:  if (r_cnt != 2'd2) n_st = pkhs_pkg::F_IDLE;
            default:           n_st = pkhs_pkg::F_IDLE;
        endcase
    end

    assign w_enq = (r_st == pkhs_pkg::F_PUSH) && (r_cnt != 2'd2);
    assign w_deq = i_op_take && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= pkhs_pkg::F_IDLE;
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            r_st <= n_st;
            if (w_enq) r_wp <= ~r_wp;
            if (w_deq) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_enq) - 2'(w_deq);
        end
    end

    // datapath: split 41x42 product into two narrow multiplies
    always_ff @(posedge i_clk) begin
        case (r_st)
            pkhs_pkg::F_IDLE: begin
                r_a   <= i_tier_value;
                r_b   <= i_position_value;
                r_clr <= (i_kind == pkhs_pkg::K_CLEAR);
                r_ins <= (i_kind == pkhs_pkg::K_INSERT);
            end
            pkhs_pkg::F_MULLO: begin
                if (r_a[0] ^ r_b[0]) begin
                    r_x <= 41'({25'd0, r_a} + {1'b0, r_b});
                    r_y <= 42'(({26'd0, r_a} + {2'b0, r_b} + 42'd1) >> 1);
                end else begin
                    r_x <= 41'(({25'd0, r_a} + {1'b0, r_b}) >> 1);
                    r_y <= 42'({26'd0, r_a} + {2'b0, r_b} + 42'd1);
                end
                r_rem  <= '0;
                r_mcnt <= 2'd0;
            end
            pkhs_pkg::F_MULHI: begin
                r_lo <= 64'(r_x * {22'd0, r_y[20:0]});
                r_hi <= 64'(r_x * {21'd0, r_y[41:21]});
            end
            pkhs_pkg::F_ADD: r_p <= r_lo + (r_hi << 21) + {48'd0, r_a};
            pkhs_pkg::F_MOD: begin
                r_rem  <= n_rem;
                r_mcnt <= r_mcnt + 2'd1;
            end
            default: ;
        endcase
        if (w_enq) begin
            r_q[r_wp].clr  <= r_clr;
            r_q[r_wp].ins  <= r_ins;
            r_q[r_wp].key  <= {r_a, r_b};
            r_q[r_wp].home <= pkhs_pkg::SlotW'(r_rem);
        end
    end

    assign o_op_valid = (r_cnt != 2'd0);
    assign o_op       = r_q[r_rp];
endmodule

@@ hdl/pkhs_back.sv @@
// Back end: probe walk over the slot store and result register
module pkhs_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_op_valid,
    input  pkhs_pkg::t_op        i_op,
    output logic                 o_op_take,
    input  logic [9:0]           i_max_fill,
    output logic                 o_empty,
    input  logic                 i_pop,
    output logic [2:0]           o_status,
    output logic [9:0]           o_occupancy,
    output logic                 o_idle
);
    localparam int N = pkhs_pkg::TableSize;
    localparam int SW = pkhs_pkg::SlotW;
    localparam int CW = pkhs_pkg::CountW;

    pkhs_pkg::t_bstate r_st, n_st;
    logic [pkhs_pkg::KeyW-1:0] r_mem [N];
    logic [pkhs_pkg::KeyW-1:0] r_rd;
    // used marks: a slot is used when its mark equals the current epoch
    logic [7:0] r_ep_mem [N];
    logic [7:0] r_ep_rd;
    logic [7:0] r_epoch;
    logic [SW-1:0] r_idx, r_sweep;
    logic [CW-1:0] r_steps, r_count;
    pkhs_pkg::t_op r_op;
    logic        r_ovalid;
    logic [2:0]  r_ostat;
    logic        w_used, w_match, w_write;
    logic [2:0]  n_stat;

    assign w_used  = (r_ep_rd == r_epoch);
    assign w_match = (r_rd == r_op.key);
    assign o_op_take = (r_st == pkhs_pkg::B_IDLE) && !r_ovalid;
    assign o_idle  = (r_st == pkhs_pkg::B_IDLE) && !i_op_valid;
    assign w_write = (r_st == pkhs_pkg::B_CHECK) && !w_used && r_op.ins
        && ({1'b0, r_count} + 11'd1 <= {1'b0, i_max_fill});

    always_comb begin
        n_st = r_st;
        n_stat = pkhs_pkg::ST_ABSENT;
        case (r_st)
            pkhs_pkg::B_IDLE:
                if (i_op_valid && !r_ovalid) n_st = pkhs_pkg::B_READ;
            pkhs_pkg::B_CLEAR:
                if (r_sweep == SW'(N - 1)) n_st = pkhs_pkg::B_IDLE;
            pkhs_pkg::B_READ: n_st = r_op.clr ? pkhs_pkg::B_OUT : pkhs_pkg::B_CHECK;
            pkhs_pkg::B_CHECK: begin
                if (!w_used) begin
                    n_st = pkhs_pkg::B_OUT;
                    n_stat = !r_op.ins ? pkhs_pkg::ST_ABSENT
                        : (w_write ? pkhs_pkg::ST_ADDED : pkhs_pkg::ST_REFUSED);
                end else if (w_match) begin
                    n_st = pkhs_pkg::B_OUT;
                    n_stat = pkhs_pkg::ST_PRESENT;
                end else if (r_steps == CW'(N - 1)) begin
                    n_st = pkhs_pkg::B_OUT;
                    n_stat = r_op.ins ? pkhs_pkg::ST_REFUSED : pkhs_pkg::ST_ABSENT;
                end else n_st = pkhs_pkg::B_READ;
            end
            // a clear that wrapped the epoch sweeps stale marks away
            pkhs_pkg::B_OUT:
                n_st = (r_op.clr && r_epoch == 8'd1) ? pkhs_pkg::B_CLEAR : pkhs_pkg::B_IDLE;
            default: n_st = pkhs_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= pkhs_pkg::B_CLEAR;
            r_sweep  <= '0;
            r_epoch  <= 8'd1;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == pkhs_pkg::B_CLEAR)
                r_sweep <= (r_sweep == SW'(N - 1)) ? '0 : r_sweep + SW'(1);
            if (i_pop && r_ovalid) r_ovalid <= 1'b0;
            if (r_st == pkhs_pkg::B_CHECK && n_st == pkhs_pkg::B_OUT) r_ostat <= n_stat;
            if (w_write) r_count <= r_count + CW'(1);
            if (r_st == pkhs_pkg::B_READ && r_op.clr) begin
                r_count <= '0;
                r_ostat <= pkhs_pkg::ST_CLEARED;
                // new epoch; zero is kept for swept marks
                r_epoch <= (r_epoch == 8'hFF) ? 8'd1 : r_epoch + 8'd1;
            end
            if (r_st == pkhs_pkg::B_OUT) r_ovalid <= 1'b1;
        end
    end

    // operation capture and probe index walk
    always_ff @(posedge i_clk) begin
        if (r_st == pkhs_pkg::B_IDLE && i_op_valid && !r_ovalid) begin
            r_op    <= i_op;
            r_idx   <= i_op.home;
            r_steps <= '0;
        end else if (r_st == pkhs_pkg::B_CHECK) begin
            r_idx   <= (r_idx == SW'(N - 1)) ? '0 : r_idx + SW'(1);
            r_steps <= r_steps + CW'(1);
        end
    end

    // memories: one write port, one registered read port each
    always_ff @(posedge i_clk) begin
        if (r_st == pkhs_pkg::B_CLEAR) r_ep_mem[r_sweep] <= 8'd0;
        else if (w_write) r_ep_mem[r_idx] <= r_epoch;
        r_ep_rd <= r_ep_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (w_write) r_mem[r_idx] <= r_op.key;
        r_rd <= r_mem[r_idx];
    end

    assign o_empty     = !r_ovalid;
    assign o_status    = r_ostat;
    assign o_occupancy = r_count[9:0];
endmodule
